// ===== rtl/core/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the slotted page record directory.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

	localparam int PAGE_BYTES    = 4096;
	localparam int SLOT_BYTES    = 4;
	localparam int HEADER_BYTES  = 24;
	localparam int NUM_PAGES_DEF = 16;
	localparam int MAX_SLOTS_DEF = 64;

	localparam int KIND_W = 2;
	localparam int PAGE_W = 4;
	localparam int LEN_W  = 13;
	localparam int SLOT_W = 6;
	localparam int ST_W   = 2;
	localparam int OFF_W  = 12;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_BADSLOT = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PAGE_W-1:0] page_number;
		logic [LEN_W-1:0]  rec_len;
		logic [SLOT_W-1:0] slot_index;
	} req_word_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SLOT_W-1:0] slot_out;
		logic [OFF_W-1:0]  record_offset;
		logic [LEN_W-1:0]  record_bytes;
	} rsp_word_t;

	typedef struct packed {
		logic [LEN_W-1:0] lower;
		logic [LEN_W-1:0] upper;
	} hdr_t;

	typedef struct packed {
		logic             gone;
		logic [LEN_W-1:0] length;
		logic [OFF_W-1:0] offset;
	} slot_ent_t;

	localparam hdr_t HDR_RESET = '{
		lower: LEN_W'(HEADER_BYTES),
		upper: LEN_W'(PAGE_BYTES)
	};

endpackage

`default_nettype wire

// ===== rtl/core/spd_hdr_store.sv =====
// ----------------------------------------------------------------------------
// spd_hdr_store
// Per-page header memory (bounds and slot count) with per-page valid bits;
// a page never written reads back as a fresh page.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_hdr_store #(
	parameter int NUM_PAGES = spd_pkg::NUM_PAGES_DEF,
	parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF,
	localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
	localparam int CW = $clog2(MAX_SLOTS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [PW-1:0] rd_page,
	input  wire logic          wr_en,
	input  wire logic [PW-1:0] wr_page,
	input  wire spd_pkg::hdr_t wr_hdr,
	input  wire logic [CW-1:0] wr_count,
	output spd_pkg::hdr_t      rd_hdr,
	output logic [CW-1:0]      rd_count
);
	import spd_pkg::*;

	hdr_t              hdr_mem_q [NUM_PAGES];
	logic [CW-1:0]     cnt_mem_q [NUM_PAGES];
	logic [NUM_PAGES-1:0] vld_q;
	hdr_t              rd_hdr_q;
	logic [CW-1:0]     rd_cnt_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hdr_mem_q[wr_page] <= wr_hdr;
			cnt_mem_q[wr_page] <= wr_count;
		end
		if (rd_en) begin
			rd_hdr_q <= hdr_mem_q[rd_page];
			rd_cnt_q <= cnt_mem_q[rd_page];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_page] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_page];
			end
		end
	end

	assign rd_hdr   = rd_vld_q ? rd_hdr_q : HDR_RESET;
	assign rd_count = rd_vld_q ? rd_cnt_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/slotted_page_record_directory.sv =====
// ----------------------------------------------------------------------------
// slotted_page_record_directory
// Slot directories of a set of slotted pages: insert, delete and lookup.
// ----------------------------------------------------------------------------
// Path, accept to rsp_valid: delete and lookup of a live slot pass S_DECIDE,
//   S_ENTRY and S_FINISH; a bad slot, unused kind or insert without space go
//   from S_DECIDE to S_FINISH; an insert scans for a reusable slot in S_SCAN or appends in S_APPEND.
//   One slot entry is read per cycle from the slot memory during the scan.
// Throughput: one word at a time; req_stall is low only while idle.
// Reset: all pages read as fresh through per-page valid bits; slot memory
//   is not cleared and needs no clearing pass.
`default_nettype none

module slotted_page_record_directory #(
	parameter int NUM_PAGES = spd_pkg::NUM_PAGES_DEF,
	parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire spd_pkg::req_word_t req_word,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output spd_pkg::rsp_word_t rsp_word
);
	import spd_pkg::*;

	localparam int PW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW     = $clog2(MAX_SLOTS + 1);
	localparam int NPW    = $clog2(NUM_PAGES + 1);
	localparam int PCMP_W = (NPW > PAGE_W) ? NPW : PAGE_W;
	localparam int SCMP_W = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int AW     = PW + SW;
	localparam int DEPTH  = NUM_PAGES * (2 ** SW);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_ENTRY  = 6'b000100,
		S_SCAN   = 6'b001000,
		S_APPEND = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t         state_q, state_d;
	req_word_t      req_q;
	rsp_word_t      res_q, res_d;
	rsp_word_t      rsp_q;
	logic           rsp_valid_q;
	logic [CW-1:0]  idx_q, idx_d, idx_nx;
	slot_ent_t      slot_mem [DEPTH];
	slot_ent_t      ent_rd_q;

	logic           accept;
	logic           rsp_ld;
	logic [PW-1:0]  pidx;
	logic [SW-1:0]  sidx;
	hdr_t           hdr;
	logic [CW-1:0]  cnt;
	logic           hdr_wr_en;
	hdr_t           hdr_wr;
	logic [CW-1:0]  cnt_wr;

	logic           mem_rd_en;
	logic [AW-1:0]  mem_rd_addr;
	logic           mem_wr_en;
	logic [AW-1:0]  mem_wr_addr;
	slot_ent_t      mem_wr_data;

	logic [LEN_W-1:0] free_bytes;
	logic [LEN_W:0]   need_bytes;
	logic             space_ok;
	logic [LEN_W-1:0] new_off;
	logic             page_ok;
	logic             slot_ok;
	logic             hit;
	logic             last;
	logic             full;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_ld    = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	assign pidx = PW'(req_q.page_number);
	assign sidx = SW'(req_q.slot_index);

	spd_hdr_store #(
		.NUM_PAGES (NUM_PAGES),
		.MAX_SLOTS (MAX_SLOTS)
	) u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_page  (PW'(req_word.page_number)),
		.wr_en    (hdr_wr_en),
		.wr_page  (pidx),
		.wr_hdr   (hdr_wr),
		.wr_count (cnt_wr),
		.rd_hdr   (hdr),
		.rd_count (cnt)
	);

	assign free_bytes = (hdr.upper >= hdr.lower) ? (hdr.upper - hdr.lower) : '0;
	assign need_bytes = {1'b0, req_q.rec_len} + (LEN_W + 1)'(SLOT_BYTES);
	assign space_ok   = {1'b0, free_bytes} >= need_bytes;
	assign new_off    = hdr.upper - req_q.rec_len;
	assign page_ok    = PCMP_W'(req_q.page_number) < PCMP_W'(NUM_PAGES);
	assign slot_ok    = SCMP_W'(req_q.slot_index) < SCMP_W'(cnt);
	assign hit        = ent_rd_q.gone && (ent_rd_q.length >= req_q.rec_len);
	assign idx_nx     = idx_q + CW'(1);
	assign last       = idx_nx >= cnt;
	assign full       = cnt >= CW'(MAX_SLOTS);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		res_d       = res_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = {pidx, sidx};
		mem_wr_en   = 1'b0;
		mem_wr_addr = {pidx, idx_q[SW-1:0]};
		mem_wr_data = ent_rd_q;
		hdr_wr_en   = 1'b0;
		hdr_wr      = hdr;
		cnt_wr      = cnt;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				res_d        = '0;
				res_d.status = ST_BADSLOT;
				state_d      = S_FINISH;
				case (req_q.kind) inside
					KIND_INSERT: begin
						if (page_ok) begin
							if (!space_ok) begin
								res_d.status = ST_NOSPACE;
							end else if (cnt == '0) begin
								state_d = S_APPEND;
							end else begin
								mem_rd_en   = 1'b1;
								mem_rd_addr = {pidx, {SW{1'b0}}};
								idx_d       = '0;
								state_d     = S_SCAN;
							end
						end
					end
					KIND_DELETE, KIND_LOOKUP: begin
						res_d.slot_out = req_q.slot_index;
						if (page_ok && slot_ok) begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = {pidx, sidx};
							state_d     = S_ENTRY;
						end
					end
					default: begin
					end
				endcase
			end
			S_ENTRY: begin
				state_d = S_FINISH;
				if (!ent_rd_q.gone) begin
					res_d.status        = ST_OK;
					res_d.record_offset = ent_rd_q.offset;
					res_d.record_bytes  = ent_rd_q.length;
					if (req_q.kind == KIND_DELETE) begin
						mem_wr_en        = 1'b1;
						mem_wr_addr      = {pidx, sidx};
						mem_wr_data.gone = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					mem_wr_en          = 1'b1;
					mem_wr_data.gone   = 1'b0;
					mem_wr_data.length = req_q.rec_len;
					res_d.status        = ST_OK;
					res_d.slot_out      = SLOT_W'(idx_q);
					res_d.record_offset = ent_rd_q.offset;
					res_d.record_bytes  = req_q.rec_len;
					state_d             = S_FINISH;
				end else if (last) begin
					state_d = S_APPEND;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = {pidx, idx_nx[SW-1:0]};
					idx_d       = idx_nx;
				end
			end
			S_APPEND: begin
				state_d = S_FINISH;
				if (full) begin
					res_d.status = ST_NOSPACE;
				end else begin
					mem_wr_en          = 1'b1;
					mem_wr_addr        = {pidx, cnt[SW-1:0]};
					mem_wr_data.gone   = 1'b0;
					mem_wr_data.length = req_q.rec_len;
					mem_wr_data.offset = new_off[OFF_W-1:0];
					hdr_wr_en          = 1'b1;
					hdr_wr.lower       = hdr.lower + LEN_W'(SLOT_BYTES);
					hdr_wr.upper       = new_off;
					cnt_wr             = cnt + CW'(1);
					res_d.status        = ST_OK;
					res_d.slot_out      = SLOT_W'(cnt);
					res_d.record_offset = new_off[OFF_W-1:0];
					res_d.record_bytes  = req_q.rec_len;
				end
			end
			S_FINISH: begin
				if (rsp_ld) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			slot_mem[mem_wr_addr] <= mem_wr_data;
		end
		if (mem_rd_en) begin
			ent_rd_q <= slot_mem[mem_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_word;
		end
		idx_q <= idx_d;
		res_q <= res_d;
		if (rsp_ld) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/slotted_page_record_directory_test.sv =====
// ----------------------------------------------------------------------------
// slotted_page_record_directory_test
// Drives insert, delete and lookup words into the slot directory and predicts
// every reply from a behavioral copy of the page headers and slot entries.
// A directed opening hits empty, full and reused slots. Random traffic then
// fills one page at a time up to the slot limit, with noise on the rest.
// Both sides idle and stall in bursts, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module slotted_page_record_directory_test;

	import spd_pkg::*;

	localparam int                PAGES       = NUM_PAGES_DEF;
	localparam int                SLOTS       = MAX_SLOTS_DEF;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int                RANDOM_WORDS = 600;
	localparam int                STUCK_LIMIT  = 4000;
	localparam int                LONG_HOLD    = 400;
	localparam int                DRAIN_CYCLES = 80;

	class spd_scoreboard;
		int unsigned lower_b[PAGES];
		int unsigned upper_b[PAGES];
		int unsigned used[PAGES];
		int unsigned dead[PAGES];
		int unsigned s_off[PAGES][SLOTS];
		int unsigned s_len[PAGES][SLOTS];
		bit          s_gone[PAGES][SLOTS];
		rsp_word_t   pending_replies[$];
		int          errors;

		function new();
			errors = 0;
			for (int p = 0; p < PAGES; p++) begin
				lower_b[p] = HEADER_BYTES;
				upper_b[p] = PAGE_BYTES;
				used[p] = 0;
				dead[p] = 0;
				for (int s = 0; s < SLOTS; s++) begin
					s_off[p][s] = 0;
					s_len[p][s] = 0;
					s_gone[p][s] = 1'b0;
				end
			end
		endfunction

		function rsp_word_t place_record(int unsigned pg, int unsigned len);
			rsp_word_t   r;
			int unsigned room;
			int unsigned off;
			int unsigned idx;
			r = '0;
			room = (upper_b[pg] >= lower_b[pg]) ? upper_b[pg] - lower_b[pg] : 0;
			if (room < len + SLOT_BYTES) begin
				r.status = ST_NOSPACE;
				return r;
			end
			for (int unsigned i = 0; i < used[pg] && i < SLOTS; i++) begin
				if (s_gone[pg][i] && s_len[pg][i] >= len) begin
					s_gone[pg][i] = 1'b0;
					s_len[pg][i] = len;
					if (dead[pg] > 0)
						dead[pg]--;
					r.status = ST_OK;
					r.slot_out = SLOT_W'(i);
					r.record_offset = OFF_W'(s_off[pg][i]);
					r.record_bytes = LEN_W'(len);
					return r;
				end
			end
			if (used[pg] >= SLOTS) begin
				r.status = ST_NOSPACE;
				return r;
			end
			off = upper_b[pg] - len;
			idx = used[pg];
			s_off[pg][idx] = off;
			s_len[pg][idx] = len;
			s_gone[pg][idx] = 1'b0;
			upper_b[pg] = off;
			lower_b[pg] += SLOT_BYTES;
			used[pg]++;
			r.status = ST_OK;
			r.slot_out = SLOT_W'(idx);
			r.record_offset = OFF_W'(off);
			r.record_bytes = LEN_W'(len);
			return r;
		endfunction

		function void note_request(req_word_t w);
			rsp_word_t   r;
			int unsigned pg;
			int unsigned slot;
			r = '0;
			pg = w.page_number;
			slot = w.slot_index;
			if (w.kind == KIND_UNUSED) begin
				r.status = ST_BADSLOT;
			end else if (pg >= PAGES) begin
				r.status = ST_BADSLOT;
				if (w.kind != KIND_INSERT)
					r.slot_out = w.slot_index;
			end else if (w.kind == KIND_INSERT) begin
				r = place_record(pg, w.rec_len);
			end else if (slot >= used[pg] || s_gone[pg][slot]) begin
				r.status = ST_BADSLOT;
				r.slot_out = w.slot_index;
			end else begin
				if (w.kind == KIND_DELETE) begin
					s_gone[pg][slot] = 1'b1;
					dead[pg]++;
				end
				r.status = ST_OK;
				r.slot_out = w.slot_index;
				r.record_offset = OFF_W'(s_off[pg][slot]);
				r.record_bytes = LEN_W'(s_len[pg][slot]);
			end
			pending_replies.push_back(r);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			if (errors < 100)
				$display("[%0t] error: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_reply(rsp_word_t r);
			rsp_word_t e;
			if (pending_replies.size() == 0) begin
				report("unexpected reply, status", r.status, 0);
				return;
			end
			e = pending_replies.pop_front();
			if (r.status != e.status)
				report("status", r.status, e.status);
			if (r.slot_out != e.slot_out)
				report("slot_out", r.slot_out, e.slot_out);
			if (r.record_offset != e.record_offset)
				report("record_offset", r.record_offset, e.record_offset);
			if (r.record_bytes != e.record_bytes)
				report("record_bytes", r.record_bytes, e.record_bytes);
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req_word = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp_word;

	spd_scoreboard sb = new();
	bit            idle_on = 1'b0;
	bit            long_hold = 1'b0;
	int            stuck_cycles = 0;

	slotted_page_record_directory dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req_word);
			if (rsp_valid && !rsp_stall)
				sb.check_reply(rsp_word);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// reply side: short stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic req_word_t make_word(logic [KIND_W-1:0] kind, int unsigned page,
		int unsigned len, int unsigned slot);
		req_word_t w;
		w.kind = kind;
		w.page_number = PAGE_W'(page);
		w.rec_len = LEN_W'(len);
		w.slot_index = SLOT_W'(slot);
		return w;
	endfunction

	// fill page gets small records so it reaches the slot limit with space left
	function automatic req_word_t random_word(int unsigned fill_page);
		int unsigned pick;
		int unsigned pg;
		int unsigned len;
		int unsigned slot;
		logic [KIND_W-1:0] kind;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			kind = KIND_INSERT;
		else if (pick < 75)
			kind = KIND_DELETE;
		else if (pick < 96)
			kind = KIND_LOOKUP;
		else
			kind = KIND_UNUSED;
		pg = ($urandom_range(0, 9) < 8) ? fill_page : $urandom_range(0, PAGES - 1);
		pick = $urandom_range(0, 99);
		if (pg == fill_page || pick < 60)
			len = $urandom_range(0, 40);
		else if (pick < 80)
			len = $urandom_range(0, PAGE_BYTES);
		else if (pick < 93)
			len = $urandom_range(0, (1 << LEN_W) - 1);
		else
			len = ($urandom_range(0, 1) == 0) ? PAGE_BYTES : (1 << LEN_W) - 1;
		if (sb.used[pg] != 0 && $urandom_range(0, 4) != 0)
			slot = $urandom_range(0, sb.used[pg] - 1);
		else
			slot = $urandom_range(0, SLOTS - 1);
		return make_word(kind, pg, len, slot);
	endfunction

	task automatic send_word(req_word_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_word(KIND_LOOKUP, 0, 0, 0));
		send_word(make_word(KIND_DELETE, 15, 8191, 63));
		send_word(make_word(KIND_INSERT, 0, 0, 0));       // empty record at page top
		send_word(make_word(KIND_LOOKUP, 0, 0, 0));
		send_word(make_word(KIND_INSERT, 0, 8191, 0));
		send_word(make_word(KIND_INSERT, 1, 4068, 0));    // exactly fills free space
		send_word(make_word(KIND_INSERT, 1, 0, 0));
		send_word(make_word(KIND_LOOKUP, 1, 0, 0));
		send_word(make_word(KIND_DELETE, 1, 0, 0));
		send_word(make_word(KIND_LOOKUP, 1, 0, 0));
		send_word(make_word(KIND_DELETE, 1, 0, 0));
		send_word(make_word(KIND_INSERT, 1, 0, 0));       // reuse blocked by slot bytes
		send_word(make_word(KIND_INSERT, 2, 4069, 0));
		send_word(make_word(KIND_INSERT, 2, 4096, 0));
		send_word(make_word(KIND_UNUSED, 5, 8191, 63));
		send_word(make_word(KIND_INSERT, 0, 100, 0));
		send_word(make_word(KIND_INSERT, 0, 200, 0));
		send_word(make_word(KIND_DELETE, 0, 0, 1));
		send_word(make_word(KIND_INSERT, 0, 150, 0));     // hole too small
		send_word(make_word(KIND_INSERT, 0, 60, 0));      // reuses the hole
		send_word(make_word(KIND_LOOKUP, 0, 0, 1));
		send_word(make_word(KIND_LOOKUP, 0, 0, 63));
		send_word(make_word(KIND_INSERT, 3, 1, 63));

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			idle_on = (n < 450) && !(n >= 225 && n < 275);
			if (n == 60)
				long_hold = 1'b1;
			send_word(random_word(2 + n / 150));
		end
		req_valid <= 1'b0;

		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/spd_pkg.sv
rtl/core/spd_hdr_store.sv
rtl/core/slotted_page_record_directory.sv
tb/slotted_page_record_directory_test.sv
